// ===== sv/sadn_pkg.sv =====
// Shared types and constants of the six-axis deadband normaliser.
// Used by sadn_ctrl, sadn_datapath and the top level; depends on nothing.
package sadn_pkg;

	// Number of axes and fixed field widths
	localparam int N_AXES = 6;
	localparam int FS_W   = 15;
	localparam int DB_W   = 15;
	localparam int LIM_W  = 16;
	localparam int OUT_W  = 16;
	localparam int KIND_W = 2;
	localparam int BIDX_W = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Poll result kinds
	localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MOTION = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd2;
	localparam logic [KIND_W-1:0] KIND_OTHER  = 2'd3;

	// Axis order of the held values and results
	localparam int AX_FORWARD  = 0;
	localparam int AX_LATERAL  = 1;
	localparam int AX_VERTICAL = 2;
	localparam int AX_ROLL     = 3;
	localparam int AX_PITCH    = 4;
	localparam int AX_YAW      = 5;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FS_FORWARD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FS_LATERAL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FS_VERTICAL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FS_ROLL     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FS_PITCH    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FS_YAW      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT  = 3'd7;

	// Register reset values
	localparam logic [FS_W-1:0]  FS_RESET  = 15'd350;
	localparam logic [DB_W-1:0]  DB_RESET  = 15'd0;
	localparam logic [LIM_W-1:0] LIM_RESET = 16'd100;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD_Q,
		ST_DIV_Q,
		ST_LOAD_R,
		ST_DIV_R,
		ST_DONE
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic load_q;
		logic step;
		logic load_r;
		logic finish;
	} ctl_cmd_t;

endpackage

// ===== sv/sadn_ctrl.sv =====
// Sequencing controller of the six-axis deadband normaliser.
// Depends on sadn_pkg; drives the command struct of sadn_datapath.
module sadn_ctrl
	import sadn_pkg::*;
#(
	parameter int FRAC_BITS = 15
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output ctl_cmd_t cmd
);

	localparam int CNT_W = $clog2(FRAC_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS - 1);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             slot_free;

	assign slot_free = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_LOAD_Q;
			ST_LOAD_Q: state_d = ST_DIV_Q;
			ST_DIV_Q:  if (cnt_q == CNT_LAST) state_d = ST_LOAD_R;
			ST_LOAD_R: state_d = ST_DIV_R;
			ST_DIV_R:  if (cnt_q == CNT_LAST) state_d = ST_DONE;
			ST_DONE:   if (slot_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_LOAD_Q: cmd.load_q = 1'b1;
			ST_DIV_Q:  cmd.step   = 1'b1;
			ST_LOAD_R: cmd.load_r = 1'b1;
			ST_DIV_R:  cmd.step   = 1'b1;
			ST_DONE:   cmd.finish = slot_free;
			default:   cmd = '0;
		endcase
	end

	// State, step counter and result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.step) begin
				cnt_q <= (cnt_q == CNT_LAST) ? '0 : cnt_q + 1'b1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// An accepted transaction always starts the first division setup
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == ST_LOAD_Q)
		else $error("accepted transaction did not start the setup");

	// Each division starts with the step counter at zero
	a_cnt_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD_Q || state_q == ST_LOAD_R) |-> cnt_q == '0)
		else $error("step counter not cleared at division start");

	// A result appears only out of the finishing state
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the finishing state");

	// A pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while pending");

endmodule

// ===== sv/sadn_datapath.sv =====
// Datapath of the six-axis deadband normaliser: registers, held state and
// six bit-serial divider lanes. Depends on sadn_pkg; commanded by sadn_ctrl.
module sadn_datapath
	import sadn_pkg::*;
#(
	parameter int RAW_WIDTH   = 16,
	parameter int FRAC_BITS   = 15,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ctl_cmd_t                    cmd,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic [KIND_W-1:0]           kind,
	input  logic signed [RAW_WIDTH-1:0] raw_x,
	input  logic signed [RAW_WIDTH-1:0] raw_y,
	input  logic signed [RAW_WIDTH-1:0] raw_z,
	input  logic signed [RAW_WIDTH-1:0] raw_rx,
	input  logic signed [RAW_WIDTH-1:0] raw_ry,
	input  logic signed [RAW_WIDTH-1:0] raw_rz,
	input  logic [BIDX_W-1:0]           button_index,
	input  logic                        button_pressed,
	output logic signed [OUT_W-1:0]     out_axes [N_AXES],
	output logic                        out_button_one,
	output logic                        out_button_two
);

	localparam int F     = FRAC_BITS;
	// Remainder and divisor width: holds fs (15 bits) and ONE - d (up to 2^F)
	localparam int RW    = (F + 1 > FS_W + 1) ? F + 1 : FS_W + 1;
	// Width for comparing magnitude against full scale
	localparam int MW    = (RAW_WIDTH > FS_W) ? RAW_WIDTH : FS_W;
	// Width for q, d and ONE arithmetic
	localparam int EW    = ((F + 1 > DB_W) ? F + 1 : DB_W) + 1;
	localparam int CMP_W = (COUNT_WIDTH > LIM_W) ? COUNT_WIDTH : LIM_W;
	localparam logic [F:0] ONE = (F + 1)'(1) << F;
	localparam int OMAX_I = (F >= 15) ? 32767 : (1 << F) - 1;
	localparam logic [F:0] OMAX = (F + 1)'(OMAX_I);
	localparam logic signed [RAW_WIDTH-1:0] RAW_LOW = {1'b1, {(RAW_WIDTH-1){1'b0}}};
	localparam logic signed [RAW_WIDTH-1:0] RAW_HIGH = {1'b0, {(RAW_WIDTH-1){1'b1}}};

	// Configuration registers
	logic [FS_W-1:0]  fs_q [N_AXES];
	logic [DB_W-1:0]  db_q;
	logic [LIM_W-1:0] lim_q;

	// Held state
	logic signed [RAW_WIDTH-1:0] held_q [N_AXES];
	logic                        btn1_q, btn2_q;
	logic [COUNT_WIDTH-1:0]      cnt_q;

	// Lane registers
	logic          neg_q  [N_AXES];
	logic [RW-1:0] rem_q  [N_AXES];
	logic [RW-1:0] dvs_q  [N_AXES];
	logic [F-1:0]  quo_q  [N_AXES];
	logic          fix_q  [N_AXES];
	logic [F:0]    fval_q [N_AXES];

	// Result registers
	logic signed [OUT_W-1:0] res_q [N_AXES];
	logic                    rb1_q, rb2_q;

	// Event decode
	logic signed [RAW_WIDTH-1:0] motion   [N_AXES];
	logic [COUNT_WIDTH-1:0]      cnt_next;
	logic                        idle_hit;

	always_comb begin
		motion[AX_FORWARD]  = raw_z;
		motion[AX_LATERAL]  = (raw_x == RAW_LOW) ? RAW_HIGH : -raw_x;
		motion[AX_VERTICAL] = raw_y;
		motion[AX_ROLL]     = raw_rz;
		motion[AX_PITCH]    = (raw_rx == RAW_LOW) ? RAW_HIGH : -raw_rx;
		motion[AX_YAW]      = raw_ry;
		cnt_next = (kind != KIND_NONE) ? '0 : cnt_q + 1'b1;
		idle_hit = CMP_W'(cnt_next) >= CMP_W'(lim_q);
	end

	// Per-lane setup and step values
	logic [RAW_WIDTH-1:0] mag     [N_AXES];
	logic [F:0]           q_val   [N_AXES];
	logic [F:0]           r_val   [N_AXES];
	logic [RW-1:0]        sh      [N_AXES];
	logic                 fit     [N_AXES];
	logic                 q_fix   [N_AXES];
	logic [F:0]           q_fval  [N_AXES];
	logic                 r_zero  [N_AXES];
	logic                 r_full  [N_AXES];
	logic [EW-1:0]        q_e, d_e, one_e;

	always_comb begin
		d_e   = EW'(db_q);
		one_e = EW'(ONE);
		q_e   = '0;
		for (int i = 0; i < N_AXES; i++) begin
			mag[i] = held_q[i][RAW_WIDTH-1] ? RAW_WIDTH'(-held_q[i])
			                                : RAW_WIDTH'(held_q[i]);
			// First quotient: fixed when full scale is zero or |a| >= fs
			q_fix[i]  = (fs_q[i] == '0) || (MW'(mag[i]) >= MW'(fs_q[i]));
			q_fval[i] = (fs_q[i] == '0 && mag[i] == '0) ? '0 : ONE;
			q_val[i]  = fix_q[i] ? fval_q[i] : {1'b0, quo_q[i]};
			// Second quotient: zero in the deadband, full at q = ONE
			q_e       = EW'(q_val[i]);
			r_zero[i] = (d_e >= one_e) || (q_e <= d_e);
			r_full[i] = (q_e == one_e);
			r_val[i]  = fix_q[i] ? fval_q[i] : {1'b0, quo_q[i]};
			if (r_val[i] > OMAX) begin
				r_val[i] = OMAX;
			end
			// Restoring division step
			sh[i]  = {rem_q[i][RW-2:0], 1'b0};
			fit[i] = sh[i] >= dvs_q[i];
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_AXES; i++) begin
				fs_q[i] <= FS_RESET;
			end
			db_q  <= DB_RESET;
			lim_q <= LIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FS_FORWARD, REG_FS_LATERAL, REG_FS_VERTICAL,
				REG_FS_ROLL, REG_FS_PITCH, REG_FS_YAW: begin
					fs_q[cfg_index] <= cfg_data[FS_W-1:0];
				end
				REG_DEADBAND:   db_q  <= cfg_data[DB_W-1:0];
				REG_IDLE_LIMIT: lim_q <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Held axes, buttons and idle counter: update on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_AXES; i++) begin
				held_q[i] <= '0;
			end
			btn1_q <= 1'b0;
			btn2_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.accept) begin
			cnt_q <= idle_hit ? '0 : cnt_next;
			for (int i = 0; i < N_AXES; i++) begin
				if (idle_hit) begin
					held_q[i] <= '0;
				end else if (kind == KIND_MOTION) begin
					held_q[i] <= motion[i];
				end
			end
			if (kind == KIND_BUTTON) begin
				if (button_index == '0) begin
					btn1_q <= button_pressed;
				end else begin
					btn2_q <= button_pressed;
				end
			end
		end
	end

	function automatic logic [EW-1:0] q_e_lane(input logic [F:0] q);
		return EW'(q);
	endfunction

	// Divider lanes: load, step and capture
	always_ff @(posedge clk) begin
		for (int i = 0; i < N_AXES; i++) begin
			if (cmd.load_q) begin
				neg_q[i]  <= held_q[i][RAW_WIDTH-1];
				fix_q[i]  <= q_fix[i];
				fval_q[i] <= q_fval[i];
				rem_q[i]  <= RW'(mag[i]);
				dvs_q[i]  <= RW'(fs_q[i]);
				quo_q[i]  <= '0;
			end else if (cmd.load_r) begin
				fix_q[i]  <= r_zero[i] || r_full[i];
				fval_q[i] <= r_zero[i] ? '0 : OMAX;
				rem_q[i]  <= RW'(q_e_lane(q_val[i]) - d_e);
				dvs_q[i]  <= RW'(one_e - d_e);
				quo_q[i]  <= '0;
			end else if (cmd.step && !fix_q[i]) begin
				rem_q[i] <= fit[i] ? sh[i] - dvs_q[i] : sh[i];
				quo_q[i] <= {quo_q[i][F-2:0], fit[i]};
			end
			if (cmd.finish) begin
				res_q[i] <= neg_q[i] ? -OUT_W'(r_val[i]) : OUT_W'(r_val[i]);
			end
		end
		if (cmd.finish) begin
			rb1_q <= btn1_q;
			rb2_q <= btn2_q;
		end
	end

	assign out_axes       = res_q;
	assign out_button_one = rb1_q;
	assign out_button_two = rb2_q;

endmodule

// ===== sv/six_axis_deadband_normalizer.sv =====
// Top level of the six-axis deadband normaliser.
// Depends on sadn_pkg, sadn_ctrl and sadn_datapath.
//
// Each poll transaction updates the held axes, the button latches and the
// idle counter, then returns one result: six axes in signed Q1.FRAC_BITS
// (forward=z, lateral=-x, vertical=y, roll=rz, pitch=-rx, yaw=ry) scaled by
// their full-scale registers, clamped to +-1 and rescaled outside the
// deadband, plus both button states. One transaction is processed at a time;
// the six bit-serial divider lanes each run the scale division and then the
// deadband-slope division at one quotient bit per cycle. A new transaction is
// taken while a finished result still waits on out_ready. Configuration writes
// are always taken and must only be issued while the block is idle.
module six_axis_deadband_normalizer
	import sadn_pkg::*;
#(
	parameter int RAW_WIDTH   = 16,
	parameter int FRAC_BITS   = 15,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	// poll channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [KIND_W-1:0]           kind,
	input  logic signed [RAW_WIDTH-1:0] raw_x,
	input  logic signed [RAW_WIDTH-1:0] raw_y,
	input  logic signed [RAW_WIDTH-1:0] raw_z,
	input  logic signed [RAW_WIDTH-1:0] raw_rx,
	input  logic signed [RAW_WIDTH-1:0] raw_ry,
	input  logic signed [RAW_WIDTH-1:0] raw_rz,
	input  logic [BIDX_W-1:0]           button_index,
	input  logic                        button_pressed,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [OUT_W-1:0]     out_forward,
	output logic signed [OUT_W-1:0]     out_lateral,
	output logic signed [OUT_W-1:0]     out_vertical,
	output logic signed [OUT_W-1:0]     out_roll,
	output logic signed [OUT_W-1:0]     out_pitch,
	output logic signed [OUT_W-1:0]     out_yaw,
	output logic                        out_button_one,
	output logic                        out_button_two
);

	ctl_cmd_t                cmd;
	logic signed [OUT_W-1:0] axes [N_AXES];

	// Registers take a write in any cycle
	assign cfg_ready = 1'b1;

	sadn_ctrl #(
		.FRAC_BITS (FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	sadn_datapath #(
		.RAW_WIDTH   (RAW_WIDTH),
		.FRAC_BITS   (FRAC_BITS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_we         (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.kind           (kind),
		.raw_x          (raw_x),
		.raw_y          (raw_y),
		.raw_z          (raw_z),
		.raw_rx         (raw_rx),
		.raw_ry         (raw_ry),
		.raw_rz         (raw_rz),
		.button_index   (button_index),
		.button_pressed (button_pressed),
		.out_axes       (axes),
		.out_button_one (out_button_one),
		.out_button_two (out_button_two)
	);

	assign out_forward  = axes[AX_FORWARD];
	assign out_lateral  = axes[AX_LATERAL];
	assign out_vertical = axes[AX_VERTICAL];
	assign out_roll     = axes[AX_ROLL];
	assign out_pitch    = axes[AX_PITCH];
	assign out_yaw      = axes[AX_YAW];

endmodule
